[src/cau_pkg.sv]
// ============================================================================
// cau_pkg
// Shared types, widths and helper functions of the complex arithmetic unit.
// ============================================================================
package cau_pkg;

    // Operand format: signed fixed point, DATA_WIDTH bits, FRAC_BITS fraction bits.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int MAG_WIDTH  = 2 * DATA_WIDTH + 1;
    localparam int DIV_STEPS  = 2 * DATA_WIDTH + FRAC_BITS;
    localparam int SQRT_STEPS = DATA_WIDTH;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_val_t;
    typedef logic signed [DATA_WIDTH:0]   wide_t;
    typedef logic [MAG_WIDTH-1:0]         mag_t;

    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DIV  = 3'd3,
        ACT_CONJ = 3'd4,
        ACT_NEG  = 3'd5,
        ACT_MAG2 = 3'd6,
        ACT_MAG  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_SAT  = 2'd1,
        STATUS_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0] action;
        data_t      a_re;
        data_t      a_im;
        data_t      b_re;
        data_t      b_im;
    } op_item_t;

    typedef struct packed {
        data_t   res_re;
        data_t   res_im;
        status_t status;
    } res_item_t;

    // Classified item as it waits in the queue.
    typedef struct packed {
        action_t action;
        data_t   a_re;
        data_t   a_im;
        data_t   b_re;
        data_t   b_im;
    } cls_item_t;

    // Product stage contents.
    typedef struct packed {
        action_t   action;
        prod_val_t p0;
        prod_val_t p1;
        prod_val_t p2;
        prod_val_t p3;
        prod_val_t p4;
        prod_val_t p5;
        wide_t     smp_re;
        wide_t     smp_im;
    } prod_t;

    // One stage of the divide and square root pipeline.
    typedef struct packed {
        action_t                action;
        logic                   divz;
        logic                   re_neg;
        logic                   im_neg;
        mag_t                   re_mag;
        mag_t                   im_mag;
        logic [DIV_STEPS-1:0]   num_re;
        logic [DIV_STEPS-1:0]   num_im;
        logic [PROD_WIDTH-1:0]  den;
        logic [PROD_WIDTH-1:0]  rem_re;
        logic [PROD_WIDTH-1:0]  rem_im;
        logic [DATA_WIDTH:0]    q_re;
        logic [DATA_WIDTH:0]    q_im;
        logic                   ovf_re;
        logic                   ovf_im;
        logic [PROD_WIDTH-1:0]  sq;
        logic [DATA_WIDTH+1:0]  srem;
        logic [DATA_WIDTH-1:0]  root;
    } pipe_t;

    typedef struct packed {
        logic  sat;
        data_t value;
    } enc_t;

    localparam mag_t LIM_POS = {{(MAG_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam mag_t LIM_NEG = LIM_POS + mag_t'(1);

    function automatic prod_val_t smul(data_t x, data_t y);
        return prod_val_t'(x) * prod_val_t'(y);
    endfunction

    function automatic wide_t sext(data_t x);
        return {x[DATA_WIDTH-1], x};
    endfunction

    // Saturate a sign and magnitude value into the output format.
    function automatic enc_t encode_part(logic neg, mag_t mag);
        enc_t                  r;
        mag_t                  lim;
        logic [DATA_WIDTH-1:0] m;
        lim     = neg ? LIM_NEG : LIM_POS;
        r.sat   = (mag > lim);
        m       = r.sat ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
        r.value = data_t'(neg ? (~m + 1'b1) : m);
        return r;
    endfunction

endpackage

[src/cau_front.sv]
// ============================================================================
// cau_front
// Input stage: takes operand transfers, classifies them and feeds the queue.
// ============================================================================
module cau_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_stall,
    input  cau_pkg::op_item_t   op_data,
    output logic                push,
    output cau_pkg::cls_item_t  push_data,
    input  logic                full
);
    import cau_pkg::*;

    logic      hold_valid_reg;
    logic      hold_valid_next;
    cls_item_t hold_reg;
    cls_item_t hold_next;
    logic      accept;

    assign op_stall  = hold_valid_reg && full;
    assign accept    = op_valid && !op_stall;
    assign push      = hold_valid_reg && !full;
    assign push_data = hold_reg;

    // The magnitude operations square a, so operand b is replaced by a here.
    always_comb
    begin
        hold_next.action = action_t'(op_data.action);
        hold_next.a_re   = op_data.a_re;
        hold_next.a_im   = op_data.a_im;
        hold_next.b_re   = op_data.b_re;
        hold_next.b_im   = op_data.b_im;
        if (hold_next.action == ACT_MAG2 || hold_next.action == ACT_MAG)
        begin
            hold_next.b_re = op_data.a_re;
            hold_next.b_im = op_data.a_im;
        end
    end

    assign hold_valid_next = accept || (hold_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= hold_next;
        end
    end

endmodule

[src/cau_queue.sv]
// ============================================================================
// cau_queue
// Small first-in first-out queue between the front and back parts.
// ============================================================================
module cau_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cau_pkg::cls_item_t  push_data,
    output logic                full,
    output logic                pop_valid,
    input  logic                pop,
    output cau_pkg::cls_item_t  pop_data
);
    import cau_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue holds more entries than its depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue popped while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

endmodule

[src/cau_back.sv]
// ============================================================================
// cau_back
// Execution pipeline: products, sums, restoring divide and square root steps,
// then saturation into the output register.
// ============================================================================
module cau_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cau_pkg::cls_item_t  q_data,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_stall,
    output cau_pkg::res_item_t  res_data
);
    import cau_pkg::*;

    logic                 advance;
    logic                 s1_valid_reg;
    prod_t                s1_reg;
    prod_t                s1_next;
    logic [DIV_STEPS:0]   vld_reg;
    pipe_t                pipe_reg  [DIV_STEPS+1];
    pipe_t                pipe_next [DIV_STEPS+1];
    logic                 out_valid_reg;
    res_item_t            out_reg;
    res_item_t            out_next;

    // The whole pipeline moves together unless a finished result is held.
    assign advance   = !out_valid_reg || !res_stall;
    assign q_pop     = advance && q_valid;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // Products and the simple operations.
    always_comb
    begin
        s1_next.action = q_data.action;
        s1_next.p0     = smul(q_data.a_re, q_data.b_re);
        s1_next.p1     = smul(q_data.a_im, q_data.b_im);
        s1_next.p2     = smul(q_data.a_re, q_data.b_im);
        s1_next.p3     = smul(q_data.a_im, q_data.b_re);
        s1_next.p4     = smul(q_data.b_re, q_data.b_re);
        s1_next.p5     = smul(q_data.b_im, q_data.b_im);
        unique case (q_data.action)
            ACT_ADD:
            begin
                s1_next.smp_re = sext(q_data.a_re) + sext(q_data.b_re);
                s1_next.smp_im = sext(q_data.a_im) + sext(q_data.b_im);
            end
            ACT_SUB:
            begin
                s1_next.smp_re = sext(q_data.a_re) - sext(q_data.b_re);
                s1_next.smp_im = sext(q_data.a_im) - sext(q_data.b_im);
            end
            ACT_CONJ:
            begin
                s1_next.smp_re = sext(q_data.a_re);
                s1_next.smp_im = -sext(q_data.a_im);
            end
            ACT_NEG:
            begin
                s1_next.smp_re = -sext(q_data.a_re);
                s1_next.smp_im = -sext(q_data.a_im);
            end
            default:
            begin
                s1_next.smp_re = '0;
                s1_next.smp_im = '0;
            end
        endcase
    end

    // Sums of products, split into sign and magnitude.
    always_comb
    begin
        logic signed [MAG_WIDTH-1:0] x;
        logic signed [MAG_WIDTH-1:0] y;
        mag_t                        mx;
        mag_t                        my;
        logic [PROD_WIDTH-1:0]       den;
        unique case (s1_reg.action)
            ACT_MUL:
            begin
                x = MAG_WIDTH'(s1_reg.p0) - MAG_WIDTH'(s1_reg.p1);
                y = MAG_WIDTH'(s1_reg.p2) + MAG_WIDTH'(s1_reg.p3);
            end
            ACT_DIV:
            begin
                x = MAG_WIDTH'(s1_reg.p0) + MAG_WIDTH'(s1_reg.p1);
                y = MAG_WIDTH'(s1_reg.p3) - MAG_WIDTH'(s1_reg.p2);
            end
            ACT_MAG2, ACT_MAG:
            begin
                x = MAG_WIDTH'(s1_reg.p0) + MAG_WIDTH'(s1_reg.p1);
                y = '0;
            end
            default:
            begin
                x = MAG_WIDTH'(s1_reg.smp_re);
                y = MAG_WIDTH'(s1_reg.smp_im);
            end
        endcase
        den = PROD_WIDTH'(s1_reg.p4 + s1_reg.p5);
        mx  = x[MAG_WIDTH-1] ? mag_t'(-x) : mag_t'(x);
        my  = y[MAG_WIDTH-1] ? mag_t'(-y) : mag_t'(y);

        pipe_next[0].action = s1_reg.action;
        pipe_next[0].divz   = (den == '0);
        pipe_next[0].re_neg = x[MAG_WIDTH-1];
        pipe_next[0].im_neg = y[MAG_WIDTH-1];
        if (s1_reg.action == ACT_MUL || s1_reg.action == ACT_MAG2)
        begin
            pipe_next[0].re_mag = mx >> FRAC_BITS;
            pipe_next[0].im_mag = my >> FRAC_BITS;
        end
        else
        begin
            pipe_next[0].re_mag = mx;
            pipe_next[0].im_mag = my;
        end
        pipe_next[0].num_re = DIV_STEPS'(mx[PROD_WIDTH-1:0]) << FRAC_BITS;
        pipe_next[0].num_im = DIV_STEPS'(my[PROD_WIDTH-1:0]) << FRAC_BITS;
        pipe_next[0].den    = den;
        pipe_next[0].rem_re = '0;
        pipe_next[0].rem_im = '0;
        pipe_next[0].q_re   = '0;
        pipe_next[0].q_im   = '0;
        pipe_next[0].ovf_re = 1'b0;
        pipe_next[0].ovf_im = 1'b0;
        pipe_next[0].sq     = mx[PROD_WIDTH-1:0];
        pipe_next[0].srem   = '0;
        pipe_next[0].root   = '0;
    end

    // One quotient bit per stage for both parts; one root bit per stage in
    // the first stages.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        always_comb
        begin
            pipe_t                 n;
            logic [PROD_WIDTH:0]   tr;
            logic [PROD_WIDTH:0]   ti;
            logic [DATA_WIDTH+3:0] st;
            logic [DATA_WIDTH+3:0] trial;
            n  = pipe_reg[k];
            tr = {n.rem_re, n.num_re[DIV_STEPS-1]};
            ti = {n.rem_im, n.num_im[DIV_STEPS-1]};
            n.num_re = n.num_re << 1;
            n.num_im = n.num_im << 1;
            n.ovf_re = n.ovf_re | n.q_re[DATA_WIDTH];
            n.ovf_im = n.ovf_im | n.q_im[DATA_WIDTH];
            if (tr >= {1'b0, n.den})
            begin
                tr     = tr - {1'b0, n.den};
                n.q_re = {n.q_re[DATA_WIDTH-1:0], 1'b1};
            end
            else
            begin
                n.q_re = {n.q_re[DATA_WIDTH-1:0], 1'b0};
            end
            if (ti >= {1'b0, n.den})
            begin
                ti     = ti - {1'b0, n.den};
                n.q_im = {n.q_im[DATA_WIDTH-1:0], 1'b1};
            end
            else
            begin
                n.q_im = {n.q_im[DATA_WIDTH-1:0], 1'b0};
            end
            n.rem_re = tr[PROD_WIDTH-1:0];
            n.rem_im = ti[PROD_WIDTH-1:0];
            st    = {n.srem, n.sq[PROD_WIDTH-1 -: 2]};
            trial = (DATA_WIDTH+4)'({n.root, 2'b01});
            if (k < SQRT_STEPS)
            begin
                n.sq = n.sq << 2;
                if (st >= trial)
                begin
                    st     = st - trial;
                    n.root = {n.root[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    n.root = {n.root[DATA_WIDTH-2:0], 1'b0};
                end
                n.srem = st[DATA_WIDTH+1:0];
            end
            pipe_next[k+1] = n;
        end
    end

    // Final selection and saturation.
    always_comb
    begin
        pipe_t f;
        logic  rn;
        logic  inn;
        mag_t  rm;
        mag_t  imm;
        enc_t  er;
        enc_t  ei;
        f   = pipe_reg[DIV_STEPS];
        rn  = f.re_neg;
        inn = f.im_neg;
        rm  = f.re_mag;
        imm = f.im_mag;
        unique case (f.action)
            ACT_DIV:
            begin
                rm  = MAG_WIDTH'({f.ovf_re, f.q_re});
                imm = MAG_WIDTH'({f.ovf_im, f.q_im});
            end
            ACT_MAG:
            begin
                rn  = 1'b0;
                rm  = MAG_WIDTH'(f.root);
                inn = 1'b0;
                imm = '0;
            end
            ACT_MAG2:
            begin
                rn  = 1'b0;
                inn = 1'b0;
                imm = '0;
            end
            default:
            begin
            end
        endcase
        er = encode_part(rn, rm);
        ei = encode_part(inn, imm);
        out_next.res_re = er.value;
        out_next.res_im = ei.value;
        out_next.status = (er.sat || ei.sat) ? STATUS_SAT : STATUS_OK;
        if (f.action == ACT_DIV && f.divz)
        begin
            out_next.res_re = '0;
            out_next.res_im = '0;
            out_next.status = STATUS_DIVZ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_pop;
            vld_reg       <= {vld_reg[DIV_STEPS-1:0], s1_valid_reg};
            out_valid_reg <= vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
            out_reg <= out_next;
        end
    end

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == STATUS_DIVZ) |->
            (out_reg.res_re == '0 && out_reg.res_im == '0))
        else $error("division by zero result is not zero");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_stall) |-> (!q_pop ##1 $stable(vld_reg)))
        else $error("pipeline moved while a result was held");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_data)))
        else $error("held result changed before its transfer");

endmodule

[src/complex_arithmetic_unit_top.sv]
// Operands use the default Q16.16 format. Throughput: one transfer per cycle while
// no result is held by res_stall; the 80-stage restoring divider sets the depth.
// Reset: rst_n clears all valid bits and queue pointers at once; payload is not reset.
// ============================================================================
// complex_arithmetic_unit_top
// Complex arithmetic on signed fixed-point operands with saturation.
// ============================================================================
module complex_arithmetic_unit_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_stall,
    input  cau_pkg::op_item_t   op_data,
    output logic                res_valid,
    input  logic                res_stall,
    output cau_pkg::res_item_t  res_data
);
    import cau_pkg::*;

    // The front registers each transfer and classifies it; the queue lets
    // the front keep taking transfers while the back part holds a result.
    logic      push;
    cls_item_t push_data;
    logic      full;
    logic      pop_valid;
    logic      pop;
    cls_item_t pop_data;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    cau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    // The back part is one pipeline for every operation, so results leave
    // in the order their transfers arrived.
    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_data    (pop_data),
        .q_pop     (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

[dv/complex_arithmetic_unit_top_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// complex_arithmetic_unit_top_tb
// Self-checking testbench for the complex arithmetic unit. A short table of
// directed transfers covers every action, the saturation limits and division
// by zero. Random transfers follow, with random gaps on both handshakes.
// Every result is compared with a typed-in value or a bit-exact predictor.
// ============================================================================
module complex_arithmetic_unit_top_tb;

    import cau_pkg::*;

    localparam int  N_RANDOM    = 1830;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  HOLD_CYCLES = 400;
    localparam int  TAIL_CYCLES = 200;
    localparam int  SIGNED_W    = 130;

    typedef logic signed [SIGNED_W-1:0] big_t;

    // One row of the directed table. Where fixed is set, the expected result
    // is typed in below; otherwise the predictor supplies it.
    typedef struct {
        op_item_t  op;
        bit        fixed;
        res_item_t res;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       op_valid;
    logic       op_stall;
    op_item_t   op_data;
    logic       res_valid;
    logic       res_stall;
    res_item_t  res_data;

    // The typed-in expectation travels beside the payload of each transfer.
    bit         cur_fixed;
    res_item_t  cur_res;

    res_item_t  pending_q[$];
    int         mismatches;
    int         cycles;
    bit         hold_req;
    bit         quiet;
    int         stall_left;

    dir_row_t   dir_tab[];

    complex_arithmetic_unit_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // The clock toggles every 2 ns, giving a 4 ns period.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Truncate a signed value toward zero by sh bits, then saturate it to the
    // data width. The saturation flag is sticky across both parts.
    function automatic data_t clamp_part(big_t v, int sh, inout bit sat);
        logic [SIGNED_W-1:0] m;
        logic                neg;
        neg = v < 0;
        m   = neg ? -v : v;
        m   = m >> sh;
        if (neg && m > 130'h80000000)
        begin
            m   = 130'h80000000;
            sat = 1'b1;
        end
        else if (!neg && m > 130'h7fffffff)
        begin
            m   = 130'h7fffffff;
            sat = 1'b1;
        end
        return data_t'(neg ? (~m[31:0] + 32'd1) : m[31:0]);
    endfunction

    // Signed quotient of num * 2^FRAC_BITS over a positive den, toward zero.
    function automatic big_t frac_quotient(big_t num, big_t den);
        logic [SIGNED_W-1:0] m;
        m = (num < 0) ? -num : num;
        m = (m << FRAC_BITS) / den;
        return (num < 0) ? -big_t'(m) : big_t'(m);
    endfunction

    // Bit-exact expected result of one transfer.
    function automatic res_item_t calc_result(op_item_t it);
        big_t      ar;
        big_t      ai;
        big_t      br;
        big_t      bi;
        big_t      den;
        big_t      acc;
        big_t      root;
        big_t      trial;
        res_item_t r;
        bit        sat;
        int        b;
        ar  = it.a_re;
        ai  = it.a_im;
        br  = it.b_re;
        bi  = it.b_im;
        sat = 1'b0;
        r.res_im = '0;
        case (action_t'(it.action))
            ACT_ADD:
            begin
                r.res_re = clamp_part(ar + br, 0, sat);
                r.res_im = clamp_part(ai + bi, 0, sat);
            end
            ACT_SUB:
            begin
                r.res_re = clamp_part(ar - br, 0, sat);
                r.res_im = clamp_part(ai - bi, 0, sat);
            end
            ACT_MUL:
            begin
                r.res_re = clamp_part(ar * br - ai * bi, FRAC_BITS, sat);
                r.res_im = clamp_part(ar * bi + ai * br, FRAC_BITS, sat);
            end
            ACT_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    r.res_re = '0;
                    r.res_im = '0;
                    r.status = STATUS_DIVZ;
                    return r;
                end
                r.res_re = clamp_part(frac_quotient(ar * br + ai * bi, den), 0, sat);
                r.res_im = clamp_part(frac_quotient(ai * br - ar * bi, den), 0, sat);
            end
            ACT_CONJ:
            begin
                r.res_re = clamp_part(ar, 0, sat);
                r.res_im = clamp_part(-ai, 0, sat);
            end
            ACT_NEG:
            begin
                r.res_re = clamp_part(-ar, 0, sat);
                r.res_im = clamp_part(-ai, 0, sat);
            end
            ACT_MAG2:
            begin
                r.res_re = clamp_part(ar * ar + ai * ai, FRAC_BITS, sat);
            end
            default:
            begin
                acc  = ar * ar + ai * ai;
                root = 0;
                for (b = 32; b >= 0; b--)
                begin
                    trial = root | (big_t'(1) << b);
                    if (trial * trial <= acc)
                        root = trial;
                end
                r.res_re = clamp_part(root, 0, sat);
            end
        endcase
        r.status = sat ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    // Operand values: mostly full range, some small, some at the limits.
    function automatic data_t rand_operand();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return data_t'($urandom);
        else if (pick < 80)
            return data_t'($urandom_range(0, 32'h0008_0000)) - data_t'(32'h0004_0000);
        else if (pick < 88)
            return 32'sh7fffffff;
        else if (pick < 95)
            return 32'sh80000000;
        else
            return '0;
    endfunction

    function automatic op_item_t rand_item();
        op_item_t it;
        it.action = 3'($urandom_range(0, 7));
        it.a_re   = rand_operand();
        it.a_im   = rand_operand();
        it.b_re   = rand_operand();
        it.b_im   = rand_operand();
        // Divisions by zero should turn up now and then.
        if (action_t'(it.action) == ACT_DIV && $urandom_range(0, 9) == 0)
        begin
            it.b_re = '0;
            it.b_im = '0;
        end
        return it;
    endfunction

    // Gap between transfers: mostly none or short, now and then long.
    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 65)
            return 0;
        else if (pick < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Offer one transfer, called just after a rising edge, and return just
    // after the edge at which it was taken. Valid stays high on return, so a
    // back-to-back transfer only needs the next payload.
    task automatic send_op(op_item_t it, bit fixed, res_item_t res);
        op_valid  <= 1'b1;
        op_data   <= it;
        cur_fixed <= fixed;
        cur_res   <= res;
        do
            @(posedge clk);
        while (op_stall);
    endtask

    task automatic idle_for(int n);
        if (n > 0)
        begin
            op_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic op_item_t mk_op(action_t act, data_t a_re, data_t a_im,
                                      data_t b_re, data_t b_im);
        op_item_t it;
        it.action = act;
        it.a_re   = a_re;
        it.a_im   = a_im;
        it.b_re   = b_re;
        it.b_im   = b_im;
        return it;
    endfunction

    function automatic res_item_t mk_res(data_t re, data_t im, status_t st);
        res_item_t r;
        r.res_re = re;
        r.res_im = im;
        r.status = st;
        return r;
    endfunction

    // Acceptance on the operand side queues the expected result. Sampling
    // at the edge sees the values from before the edge, so no race arises.
    always @(posedge clk)
    begin
        if (rst_n && op_valid && !op_stall)
        begin
            if (cur_fixed)
                pending_q.push_back(cur_res);
            else
                pending_q.push_back(calc_result(op_data));
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: re=%h im=%h status=%0d",
                             res_data.res_re, res_data.res_im, res_data.status);
            end
            else
            begin
                want = pending_q.pop_front();
                if (res_data.res_re !== want.res_re || res_data.res_im !== want.res_im
                    || res_data.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected re=%h im=%h status=%0d, ",
                                  "got re=%h im=%h status=%0d"},
                                 want.res_re, want.res_im, want.status,
                                 res_data.res_re, res_data.res_im, res_data.status);
                end
            end
        end
    end

    // Result-side back-pressure. A hold request keeps stall high for a long,
    // counted stretch so the pipeline fills and the input side stalls.
    initial
    begin
        res_stall  = 1'b1;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                res_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 99) < 20)
            begin
                res_stall  <= 1'b1;
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 3);
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a run that overstays the cycle budget counts as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int i;
        op_valid   = 1'b0;
        op_data    = '0;
        cur_fixed  = 1'b0;
        cur_res    = '0;
        hold_req   = 1'b0;
        quiet      = 1'b0;
        mismatches = 0;
        cycles     = 0;
        rst_n      = 1'b0;

        // Directed rows: limits, every action and division by zero.
        dir_tab = '{
            '{mk_op(ACT_ADD, 0, 0, 0, 0), 1'b1, mk_res(0, 0, STATUS_OK)},
            '{mk_op(ACT_ADD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff),
              1'b1, mk_res(32'sh7fffffff, 32'sh7fffffff, STATUS_SAT)},
            '{mk_op(ACT_ADD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000),
              1'b1, mk_res(32'sh80000000, 32'sh80000000, STATUS_SAT)},
            '{mk_op(ACT_SUB, 32'sh80000000, 0, 1, 0),
              1'b1, mk_res(32'sh80000000, 0, STATUS_SAT)},
            '{mk_op(ACT_SUB, 32'sh00030000, 32'sh00010000, 32'sh00010000, 32'sh00020000),
              1'b1, mk_res(32'sh00020000, -32'sh00010000, STATUS_OK)},
            '{mk_op(ACT_MUL, 32'sh00010000, 32'sh00020000, 32'sh00030000, -32'sh00010000),
              1'b0, '0},
            '{mk_op(ACT_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000),
              1'b0, '0},
            '{mk_op(ACT_MUL, -32'sh00000001, 0, 32'sh00000001, 0), 1'b0, '0},
            '{mk_op(ACT_DIV, 32'sh7fffffff, 32'sh80000000, 0, 0),
              1'b1, mk_res(0, 0, STATUS_DIVZ)},
            '{mk_op(ACT_DIV, 32'sh00040000, 32'sh00020000, 32'sh00010000, 32'sh00010000),
              1'b0, '0},
            '{mk_op(ACT_DIV, 32'sh7fffffff, 32'sh7fffffff, 1, 0), 1'b0, '0},
            '{mk_op(ACT_DIV, 1, 0, 32'sh80000000, 32'sh80000000), 1'b0, '0},
            '{mk_op(ACT_CONJ, 32'sh12345678, 32'sh80000000, 0, 0),
              1'b1, mk_res(32'sh12345678, 32'sh7fffffff, STATUS_SAT)},
            '{mk_op(ACT_CONJ, -32'sh00010000, 32'sh7fffffff, 0, 0),
              1'b1, mk_res(-32'sh00010000, -32'sh7fffffff, STATUS_OK)},
            '{mk_op(ACT_NEG, 32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff),
              1'b1, mk_res(32'sh7fffffff, 0, STATUS_SAT)},
            '{mk_op(ACT_NEG, 32'sh7fffffff, -32'sh00000001, 0, 0),
              1'b1, mk_res(-32'sh7fffffff, 32'sh00000001, STATUS_OK)},
            '{mk_op(ACT_MAG2, 32'sh00030000, 32'sh00040000, 0, 0),
              1'b1, mk_res(32'sh00190000, 0, STATUS_OK)},
            '{mk_op(ACT_MAG2, 32'sh80000000, 32'sh80000000, 0, 0),
              1'b1, mk_res(32'sh7fffffff, 0, STATUS_SAT)},
            '{mk_op(ACT_MAG, 32'sh00030000, -32'sh00040000, 0, 0),
              1'b1, mk_res(32'sh00050000, 0, STATUS_OK)},
            '{mk_op(ACT_MAG, 32'sh80000000, 32'sh80000000, 0, 0),
              1'b1, mk_res(32'sh7fffffff, 0, STATUS_SAT)},
            '{mk_op(ACT_MAG, 32'sh7fffffff, 0, 0, 0), 1'b0, '0},
            '{mk_op(ACT_MAG, 0, 0, 0, 0), 1'b1, mk_res(0, 0, STATUS_OK)}
        };

        // Reset is asserted once only, from the start of the run.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            send_op(dir_tab[i].op, dir_tab[i].fixed, dir_tab[i].res);
            idle_for(rand_gap());
        end

        for (i = 0; i < N_RANDOM; i++)
        begin
            // Stretches without idling on either side.
            if (i % 300 == 150)
                quiet = 1'b1;
            else if (i % 300 == 200)
                quiet = 1'b0;

            // Long result-side hold while the sender keeps offering transfers.
            if (i == 400 || i == 1300)
                hold_req = 1'b1;

            // Sender pause until the pipeline has drained.
            if (i == 900)
            begin
                op_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_q.size() != 0);
            end

            send_op(rand_item(), 1'b0, '0);
            if (!hold_req)
                idle_for(rand_gap());
        end
        op_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
src/cau_pkg.sv
src/cau_front.sv
src/cau_queue.sv
src/cau_back.sv
src/complex_arithmetic_unit_top.sv
dv/complex_arithmetic_unit_top_tb.sv
